### rtl/pal_pkg.sv
// Package for the positional array list: command codes, field widths
// and default sizes. No dependencies.
`default_nettype none

package pal_pkg;

	localparam int PAL_CAPACITY   = 32;
	localparam int PAL_DATA_WIDTH = 32;

	localparam int OP_W    = 2;
	localparam int POS_W   = 6;
	localparam int VAL_W   = 32;
	localparam int COUNT_W = 6;
	localparam int EXT_W   = 64;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

endpackage

`default_nettype wire

### rtl/positional_array_list.sv
// Positional array list top level: command decode, shift sequencer and
// result registers around one list RAM. Depends on pal_pkg and pal_ram.
//
// Takes one command (insert, delete or read at a list position) per transfer
// on start while busy is low, and answers each with one result marked by done
// for a single cycle; the receiver cannot stall, so results must be taken as
// they come. Entries live in a single RAM with one write and one read port,
// and shifting moves one entry per cycle through it. A refused command, an
// insert at the end of the list and a delete of the last entry are answered
// straight from idle; a read waits in ST_RDWAIT for the registered RAM read
// data; an insert or delete that moves entries passes ST_SHIFT and ST_DRAIN,
// an insert also ST_COMMIT, so the worst case is an insert at position zero.
`default_nettype none

module positional_array_list import pal_pkg::*; #(
	parameter int CAPACITY   = PAL_CAPACITY,
	parameter int DATA_WIDTH = PAL_DATA_WIDTH
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [OP_W-1:0]         op,
	input  wire logic [POS_W-1:0]        position,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                         done,
	output logic                         ok,
	output logic signed [VAL_W-1:0]      read_value,
	output logic [COUNT_W-1:0]           item_count,
	output logic                         is_empty,
	output logic                         is_full
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDWAIT,
		ST_SHIFT,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t                  state_q;
	logic [OP_W-1:0]         op_q;
	logic [AW-1:0]           pos_q;
	logic [DATA_WIDTH-1:0]   val_q;
	logic [AW-1:0]           ptr_q;
	logic [CW-1:0]           count_q;
	logic                    mv_s1;
	logic [AW-1:0]           src_s1;
	logic                    done_q;
	logic                    ok_q;
	logic [VAL_W-1:0]        rdv_q;

	logic                    accept;
	logic [XW-1:0]           pos_x;
	logic [XW-1:0]           cnt_x;
	logic [XW-1:0]           cm1_x;
	logic [AW-1:0]           pos_a;
	logic [AW-1:0]           cm1_a;
	logic                    full_c;
	logic                    ins_ok;
	logic                    rm_ok;
	logic                    ins_last;
	logic                    del_last;
	logic                    shift_last;
	logic signed [EXT_W-1:0] val_ext;
	logic [DATA_WIDTH-1:0]   val_d;
	logic signed [DATA_WIDTH-1:0] rdata_s;
	logic signed [EXT_W-1:0] rd_ext;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [DATA_WIDTH-1:0]   ram_wdata;
	logic [AW-1:0]           ram_raddr;
	logic [DATA_WIDTH-1:0]   ram_rdata;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign pos_x    = XW'(position);
	assign cnt_x    = XW'(count_q);
	assign cm1_x    = cnt_x - XW'(1);
	assign pos_a    = pos_x[AW-1:0];
	assign cm1_a    = cm1_x[AW-1:0];
	assign full_c   = (count_q == CW'(CAPACITY));
	assign ins_ok   = !full_c && (pos_x <= cnt_x);
	assign rm_ok    = (pos_x < cnt_x);
	assign ins_last = (pos_x == cnt_x);
	assign del_last = (pos_x == cm1_x);
	assign shift_last = (op_q == OP_INSERT) ? (ptr_q == pos_q) : (ptr_q == cm1_a);

	assign val_ext = EXT_W'(value);
	assign val_d   = val_ext[DATA_WIDTH-1:0];
	assign rdata_s = ram_rdata;
	assign rd_ext  = EXT_W'(rdata_s);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_a;
		ram_wdata = val_d;
		if (state_q == ST_IDLE) begin
			ram_we = accept && (op == OP_INSERT) && ins_ok && ins_last;
		end else if (mv_s1) begin
			ram_we    = 1'b1;
			ram_waddr = (op_q == OP_INSERT) ? src_s1 + AW'(1) : src_s1 - AW'(1);
			ram_wdata = ram_rdata;
		end else if (state_q == ST_COMMIT) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q;
			ram_wdata = val_q;
		end
		ram_raddr = (state_q == ST_SHIFT) ? ptr_q : pos_a;
	end

	pal_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_INSERT;
			pos_q   <= '0;
			val_q   <= '0;
			ptr_q   <= '0;
			count_q <= '0;
			mv_s1   <= 1'b0;
			src_s1  <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			rdv_q   <= '0;
		end else begin
			done_q <= 1'b0;
			mv_s1  <= (state_q == ST_SHIFT);
			src_s1 <= ptr_q;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= op;
						pos_q  <= pos_a;
						val_q  <= val_d;
						done_q <= 1'b1;
						ok_q   <= 1'b0;
						rdv_q  <= '0;
						case (op)
							OP_INSERT: begin
								if (ins_ok) begin
									if (ins_last) begin
										count_q <= count_q + CW'(1);
										ok_q    <= 1'b1;
									end else begin
										done_q  <= 1'b0;
										ptr_q   <= cm1_a;
										state_q <= ST_SHIFT;
									end
								end
							end
							OP_DELETE: begin
								if (rm_ok) begin
									if (del_last) begin
										count_q <= count_q - CW'(1);
										ok_q    <= 1'b1;
									end else begin
										done_q  <= 1'b0;
										ptr_q   <= pos_a + AW'(1);
										state_q <= ST_SHIFT;
									end
								end
							end
							OP_READ: begin
								if (rm_ok) begin
									done_q  <= 1'b0;
									state_q <= ST_RDWAIT;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_RDWAIT: begin
					done_q  <= 1'b1;
					ok_q    <= 1'b1;
					rdv_q   <= rd_ext[VAL_W-1:0];
					state_q <= ST_IDLE;
				end
				ST_SHIFT: begin
					ptr_q <= (op_q == OP_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
					if (shift_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (op_q == OP_INSERT) begin
						state_q <= ST_COMMIT;
					end else begin
						count_q <= count_q - CW'(1);
						done_q  <= 1'b1;
						ok_q    <= 1'b1;
						rdv_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_COMMIT: begin
					count_q <= count_q + CW'(1);
					done_q  <= 1'b1;
					ok_q    <= 1'b1;
					rdv_q   <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign ok         = ok_q;
	assign read_value = rdv_q;
	assign item_count = cnt_x[COUNT_W-1:0];
	assign is_empty   = (count_q == '0);
	assign is_full    = full_c;

endmodule

`default_nettype wire

### rtl/pal_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module pal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/pal_checker.sv
// Port-level checks for the positional array list, bound to the top level.
// Depends on pal_pkg for field widths.
`default_nettype none

module pal_checker import pal_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    start,
	input wire logic                    busy,
	input wire logic                    done,
	input wire logic                    ok,
	input wire logic signed [VAL_W-1:0] read_value,
	input wire logic [COUNT_W-1:0]      item_count,
	input wire logic                    is_empty,
	input wire logic                    is_full
);

	// an accepted transfer either occupies the block or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transfer neither busy nor answered");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(item_count))
		else $error("count moved without a result");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (read_value == '0))
		else $error("refused command returned data");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (item_count == '0)) && !(is_empty && is_full))
		else $error("empty or full flag disagrees with count");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

`default_nettype wire
